// ===== rtl/kml_pkg.sv =====
// Shared types and constants for the k-means clustering block.
// Holds payload structs, operation and register codes, controller states and command structs.
// No dependencies.
package kml_pkg;

  localparam logic [1:0] OP_LOAD_POINT = 2'd0;
  localparam logic [1:0] OP_LOAD_MEAN  = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_NUM_POINTS   = 2'd1;
  localparam logic [1:0] REG_NUM_DIMS     = 2'd2;
  localparam logic [1:0] REG_ITERATIONS   = 2'd3;

  localparam int CFG_DW = 8;
  localparam int CFG_AW = 2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         entry_index;
    logic [3:0]         coord_index;
    logic signed [15:0] coord_value;
  } req_t;

  typedef struct packed {
    logic [5:0] point_number;
    logic [2:0] cluster_number;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AS_RUN,
    ST_AS_DRAIN,
    ST_CL_RUN,
    ST_UP_ASG,
    ST_UP_CAP,
    ST_UP_ACC,
    ST_UP_TAIL,
    ST_DV_CHK,
    ST_DV_RD,
    ST_DV_LD,
    ST_DV_RUN,
    ST_IT_END,
    ST_OUT_RUN,
    ST_OUT_DRAIN
  } state_e;

  typedef struct packed {
    logic ld_pt;
    logic ld_mean;
    logic dist_en;
    logic first_d;
    logic last_d;
    logic first_c;
    logic last_c;
    logic clr;
    logic cnt_clr;
    logic cap;
    logic acc;
    logic dv_start;
    logic mean_wr;
    logic out;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic cnt_zero;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/kml_div.sv =====
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Returns the low 16 bits of the quotient. Standalone, no package use.
module kml_div #(
  parameter int NUMW = 23,
  parameter int DENW = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic [DENW-1:0]        den_i,
  output logic                   done_o,
  output logic [15:0]            quo_o
);
  localparam int STW = $clog2(NUMW + 1);

  logic            busy_q;
  logic            done_q;
  logic [STW-1:0]  step_q;
  logic            neg_q;
  logic [NUMW-1:0] q_q;
  logic [DENW-1:0] r_q;
  logic [DENW-1:0] den_q;
  logic [DENW:0]   trial;
  logic            ge;

  assign trial = {r_q, q_q[NUMW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STW'(NUMW);
      end else if (busy_q) begin
        step_q <= step_q - STW'(1);
        if (step_q == STW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUMW-1];
      q_q   <= num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      r_q <= ge ? DENW'(trial - {1'b0, den_q}) : DENW'(trial);
      q_q <= {q_q[NUMW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? 16'(-q_q[15:0]) : q_q[15:0];

endmodule

// ===== rtl/kml_dpath.sv =====
// Datapath: point, mean, sum and assignment memories, distance pipeline, counts, divider.
// Depends on kml_pkg and kml_div; driven by kml_ctrl commands.
module kml_dpath #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_DIMS     = 16,
  parameter int MAX_CLUSTERS = 8,
  localparam int PW   = $clog2(MAX_POINTS),
  localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int DIMW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kml_pkg::cmd_t cmd_i,
  input  logic [PW-1:0] p_i,
  input  logic [CW-1:0] c_i,
  input  logic [DIMW-1:0] d_i,
  input  kml_pkg::req_t req_i,
  output kml_pkg::sts_t sts_o,
  output logic          res_valid_o,
  output kml_pkg::res_t res_o
);
  import kml_pkg::*;

  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SW   = 17 + CNTW;
  localparam int DSTW = 33 + DIMW;
  localparam int PDEP = 1 << (PW + DIMW);
  localparam int MDEP = 1 << (CW + DIMW);
  localparam int CDEP = 1 << CW;
  localparam int ADEP = 1 << PW;

  logic signed [15:0] pmem [PDEP];
  logic signed [15:0] mmem [MDEP];
  logic signed [SW-1:0] smem [MDEP];
  logic [CW-1:0] amem [ADEP];
  logic [CNTW-1:0] cnt_q [CDEP];

  logic signed [15:0] pd_q, md_q;
  logic signed [SW-1:0] sum_q;
  logic [CW-1:0] asg_q, cl_q;

  logic s1_v_q, s2_v_q;
  logic s1_fd_q, s1_ld_q, s1_fc_q, s1_lc_q;
  logic s2_fd_q, s2_ld_q, s2_fc_q, s2_lc_q;
  logic [CW-1:0] s1_c_q, s2_c_q;
  logic [PW-1:0] s1_p_q, s2_p_q;
  logic [31:0] sq_q;
  logic [DSTW-1:0] acc_q, best_q, acc_n;
  logic [CW-1:0] bidx_q;
  logic better;

  logic acc_v_q;
  logic [CW+DIMW-1:0] acc_a_q;

  logic out_v_q, out_last_q;
  logic [PW-1:0] out_p_q;

  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic [CW-1:0] cnt_idx;
  logic [CNTW-1:0] cnt_cur;
  logic [CW+DIMW-1:0] s_raddr, m_waddr;
  logic signed [15:0] m_wdata;
  logic div_done;
  logic [15:0] quo;

  assign m_waddr = cmd_i.ld_mean ? {CW'(req_i.entry_index), DIMW'(req_i.coord_index)}
                                 : {c_i, d_i};
  assign m_wdata = cmd_i.ld_mean ? req_i.coord_value : $signed(quo);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_pt) begin
      pmem[{PW'(req_i.entry_index), DIMW'(req_i.coord_index)}] <= req_i.coord_value;
    end
    pd_q <= pmem[{p_i, d_i}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_mean || cmd_i.mean_wr) begin
      mmem[m_waddr] <= m_wdata;
    end
    md_q <= mmem[{c_i, d_i}];
  end

  assign s_raddr = cmd_i.acc ? {cl_q, d_i} : {c_i, d_i};

  always_ff @(posedge clk_i) begin
    if (acc_v_q) begin
      smem[acc_a_q] <= sum_q + SW'(pd_q);
    end else if (cmd_i.clr) begin
      smem[{c_i, d_i}] <= '0;
    end
    sum_q <= smem[s_raddr];
  end

  assign diff  = 17'(pd_q) - 17'(md_q);
  assign prod  = diff * diff;
  assign acc_n = (s2_fd_q ? '0 : acc_q) + DSTW'(sq_q);
  assign better = s2_fc_q || (acc_n < best_q);

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s2_ld_q && s2_lc_q) begin
      amem[s2_p_q] <= better ? s2_c_q : bidx_q;
    end
    asg_q <= amem[p_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      acc_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      s1_v_q   <= cmd_i.dist_en;
      s2_v_q   <= s1_v_q;
      acc_v_q  <= cmd_i.acc;
      out_v_q  <= cmd_i.out;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fd_q <= cmd_i.first_d;
    s1_ld_q <= cmd_i.last_d;
    s1_fc_q <= cmd_i.first_c;
    s1_lc_q <= cmd_i.last_c;
    s1_c_q  <= c_i;
    s1_p_q  <= p_i;
    s2_fd_q <= s1_fd_q;
    s2_ld_q <= s1_ld_q;
    s2_fc_q <= s1_fc_q;
    s2_lc_q <= s1_lc_q;
    s2_c_q  <= s1_c_q;
    s2_p_q  <= s1_p_q;
    sq_q    <= prod[31:0];
    acc_a_q <= {cl_q, d_i};
    out_p_q <= p_i;
    out_last_q <= cmd_i.out_last;
    if (s2_v_q) begin
      acc_q <= acc_n;
      if (s2_ld_q && better) begin
        best_q <= acc_n;
        bidx_q <= s2_c_q;
      end
    end
    if (cmd_i.cap) begin
      cl_q <= asg_q;
    end
  end

  assign cnt_idx = cmd_i.cap ? asg_q : c_i;
  assign cnt_cur = cnt_q[cnt_idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_clr) begin
      for (int i = 0; i < CDEP; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.cap) begin
      cnt_q[cnt_idx] <= cnt_cur + CNTW'(1);
    end
  end

  kml_div #(
    .NUMW(SW),
    .DENW(CNTW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.dv_start),
    .num_i  (sum_q),
    .den_i  (cnt_cur),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign sts_o.pipe_busy = s1_v_q || s2_v_q;
  assign sts_o.cnt_zero  = (cnt_cur == '0);
  assign sts_o.div_done  = div_done;

  assign res_valid_o          = out_v_q;
  assign res_o.point_number   = 6'(out_p_q);
  assign res_o.cluster_number = 3'(asg_q);
  assign res_o.last           = out_last_q;

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_last_q |=> !out_v_q)
    else $error("result after the final point");

  a_no_acc_in_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> !acc_v_q)
    else $error("sum update overlaps distance pipeline");

endmodule

// ===== rtl/kml_ctrl.sv =====
// Controller: configuration registers and the sequencer for load, assign, update and report.
// Depends on kml_pkg; issues commands to kml_dpath.
module kml_ctrl #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_DIMS     = 16,
  parameter int MAX_CLUSTERS = 8,
  localparam int PW   = $clog2(MAX_POINTS),
  localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int DIMW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  kml_pkg::req_t               req_i,
  input  logic                        cfg_we_i,
  input  logic [kml_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  logic [kml_pkg::CFG_DW-1:0]  cfg_data_i,
  input  kml_pkg::sts_t               sts_i,
  output kml_pkg::cmd_t               cmd_o,
  output logic [PW-1:0]               p_o,
  output logic [CW-1:0]               c_o,
  output logic [DIMW-1:0]             d_o
);
  import kml_pkg::*;

  state_e state_q, state_d;

  logic [3:0] nk_q;
  logic [6:0] np_q;
  logic [4:0] nd_q;
  logic [7:0] itcfg_q, itc_q;
  logic [PW-1:0] p_q, lp_q, lp_d;
  logic [CW-1:0] c_q, lc_q, lc_d;
  logic [DIMW-1:0] d_q, ld_q, ld_d;
  logic run_go, accept;
  logic is_ld, is_lc, is_lp;

  assign accept = start && !busy;
  assign run_go = accept && (req_i.operation == OP_RUN);
  assign is_ld  = (d_q == ld_q);
  assign is_lc  = (c_q == lc_q);
  assign is_lp  = (p_q == lp_q);

  always_comb begin
    if (np_q == '0) begin
      lp_d = '0;
    end else if (int'(np_q) > MAX_POINTS) begin
      lp_d = PW'(MAX_POINTS - 1);
    end else begin
      lp_d = PW'(np_q - 7'd1);
    end
    if (nk_q == '0) begin
      lc_d = '0;
    end else if (int'(nk_q) > MAX_CLUSTERS) begin
      lc_d = CW'(MAX_CLUSTERS - 1);
    end else begin
      lc_d = CW'(nk_q - 4'd1);
    end
    if (nd_q == '0) begin
      ld_d = '0;
    end else if (int'(nd_q) > MAX_DIMS) begin
      ld_d = DIMW'(MAX_DIMS - 1);
    end else begin
      ld_d = DIMW'(nd_q - 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nk_q    <= 4'd2;
      np_q    <= 7'd64;
      nd_q    <= 5'd16;
      itcfg_q <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_CLUSTERS: nk_q    <= cfg_data_i[3:0];
        REG_NUM_POINTS:   np_q    <= cfg_data_i[6:0];
        REG_NUM_DIMS:     nd_q    <= cfg_data_i[4:0];
        REG_ITERATIONS:   itcfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (run_go) state_d = ST_AS_RUN;
      ST_AS_RUN:    if (is_ld && is_lc && is_lp) state_d = ST_AS_DRAIN;
      ST_AS_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = (itc_q != '0) ? ST_CL_RUN : ST_OUT_RUN;
        end
      end
      ST_CL_RUN:    if (is_ld && is_lc) state_d = ST_UP_ASG;
      ST_UP_ASG:    state_d = ST_UP_CAP;
      ST_UP_CAP:    state_d = ST_UP_ACC;
      ST_UP_ACC:    if (is_ld) state_d = is_lp ? ST_UP_TAIL : ST_UP_ASG;
      ST_UP_TAIL:   state_d = ST_DV_CHK;
      ST_DV_CHK: begin
        if (sts_i.cnt_zero) begin
          if (is_lc) state_d = ST_IT_END;
        end else begin
          state_d = ST_DV_RD;
        end
      end
      ST_DV_RD:     state_d = ST_DV_LD;
      ST_DV_LD:     state_d = ST_DV_RUN;
      ST_DV_RUN: begin
        if (sts_i.div_done) begin
          if (!is_ld) state_d = ST_DV_RD;
          else state_d = is_lc ? ST_IT_END : ST_DV_CHK;
        end
      end
      ST_IT_END:    state_d = ST_AS_RUN;
      ST_OUT_RUN:   if (is_lp) state_d = ST_OUT_DRAIN;
      ST_OUT_DRAIN: state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.first_d = (d_q == '0);
    cmd_o.last_d  = is_ld;
    cmd_o.first_c = (c_q == '0);
    cmd_o.last_c  = is_lc;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.ld_pt = accept && (req_i.operation == OP_LOAD_POINT)
                      && (int'(req_i.entry_index) < MAX_POINTS)
                      && (int'(req_i.coord_index) < MAX_DIMS);
        cmd_o.ld_mean = accept && (req_i.operation == OP_LOAD_MEAN)
                        && (int'(req_i.entry_index) < MAX_CLUSTERS)
                        && (int'(req_i.coord_index) < MAX_DIMS);
      end
      ST_AS_RUN:  cmd_o.dist_en = 1'b1;
      ST_CL_RUN: begin
        cmd_o.clr     = 1'b1;
        cmd_o.cnt_clr = 1'b1;
      end
      ST_UP_CAP:  cmd_o.cap = 1'b1;
      ST_UP_ACC:  cmd_o.acc = 1'b1;
      ST_DV_LD:   cmd_o.dv_start = 1'b1;
      ST_DV_RUN:  cmd_o.mean_wr = sts_i.div_done;
      ST_OUT_RUN: begin
        cmd_o.out      = 1'b1;
        cmd_o.out_last = is_lp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      p_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      lp_q    <= '0;
      lc_q    <= '0;
      ld_q    <= '0;
      itc_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (run_go) begin
            p_q   <= '0;
            c_q   <= '0;
            d_q   <= '0;
            lp_q  <= lp_d;
            lc_q  <= lc_d;
            ld_q  <= ld_d;
            itc_q <= itcfg_q;
          end
        end
        ST_AS_RUN, ST_CL_RUN: begin
          if (is_ld) begin
            d_q <= '0;
            if (is_lc) begin
              c_q <= '0;
              p_q <= (state_q == ST_CL_RUN || is_lp) ? '0 : p_q + PW'(1);
            end else begin
              c_q <= c_q + CW'(1);
            end
          end else begin
            d_q <= d_q + DIMW'(1);
          end
        end
        ST_AS_DRAIN: begin
          p_q <= '0;
          c_q <= '0;
          d_q <= '0;
        end
        ST_UP_CAP: d_q <= '0;
        ST_UP_ACC: begin
          if (is_ld) begin
            d_q <= '0;
            if (is_lp) begin
              p_q <= '0;
              c_q <= '0;
            end else begin
              p_q <= p_q + PW'(1);
            end
          end else begin
            d_q <= d_q + DIMW'(1);
          end
        end
        ST_DV_CHK: begin
          d_q <= '0;
          if (sts_i.cnt_zero && !is_lc) c_q <= c_q + CW'(1);
        end
        ST_DV_RUN: begin
          if (sts_i.div_done) begin
            if (is_ld) begin
              d_q <= '0;
              if (!is_lc) c_q <= c_q + CW'(1);
            end else begin
              d_q <= d_q + DIMW'(1);
            end
          end
        end
        ST_IT_END: begin
          itc_q <= itc_q - 8'd1;
          p_q   <= '0;
          c_q   <= '0;
          d_q   <= '0;
        end
        ST_OUT_RUN: if (!is_lp) p_q <= p_q + PW'(1);
        default: ;
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign p_o  = p_q;
  assign c_o  = c_q;
  assign d_o  = d_q;

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !sts_i.pipe_busy)
    else $error("distance pipeline busy while idle");

  a_port_users: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.dist_en, cmd_o.clr, cmd_o.acc, cmd_o.dv_start, cmd_o.out}))
    else $error("memory port users overlap");

  a_mean_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mean_wr |-> sts_i.div_done && $past(state_q) == ST_DV_RUN
      || cmd_o.mean_wr && $past(state_q) == ST_DV_LD)
    else $error("mean written without a finished division");

endmodule

// ===== rtl/kmeans_lloyd_clustering.sv =====
// Top level of the k-means (Lloyd) clustering block.
// Depends on kml_pkg, kml_ctrl and kml_dpath.
//
// Loads (point or mean coordinate) are taken one per cycle while busy is low and give no result.
// A run holds busy high; each round steps the distance pipeline over every point, cluster and
// coordinate pair (one coordinate pair per cycle), then clears the sums, runs the sum update and
// runs the serial mean divider per coordinate of each non-empty cluster (empty clusters are
// skipped); a final assignment pass follows, then one result per point on consecutive cycles.
// Results are strobed for exactly one cycle by res_valid_o and cannot be held off.
module kmeans_lloyd_clustering #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_DIMS     = 16,
  parameter int MAX_CLUSTERS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  kml_pkg::req_t              req_i,
  input  logic                       cfg_we_i,
  input  logic [kml_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [kml_pkg::CFG_DW-1:0] cfg_data_i,
  output logic                       res_valid_o,
  output kml_pkg::res_t              res_o
);
  import kml_pkg::*;

  localparam int PW   = $clog2(MAX_POINTS);
  localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DIMW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  cmd_t cmd;
  sts_t sts;
  logic [PW-1:0] p_idx;
  logic [CW-1:0] c_idx;
  logic [DIMW-1:0] d_idx;

  kml_ctrl #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_DIMS    (MAX_DIMS),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .p_o       (p_idx),
    .c_o       (c_idx),
    .d_o       (d_idx)
  );

  kml_dpath #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_DIMS    (MAX_DIMS),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .p_i        (p_idx),
    .c_i        (c_idx),
    .d_i        (d_idx),
    .req_i      (req_i),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for kmeans_lloyd_clustering: loads, clustering runs, register phases.
// Depends on kml_pkg and the RTL; carries its own clustering predictor and a result scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kml_pkg::*;

  localparam int NPTS = 64;
  localparam int NDIM = 16;
  localparam int NCLU = 8;
  localparam int STALL_LIMIT = 300000;
  localparam int SETTLE = 40;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  req_t                req = '0;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_idx = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;
  logic                res_valid;
  res_t                res;

  kmeans_lloyd_clustering dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0] pt_mem [NPTS][NDIM];
  logic signed [15:0] mn_mem [NCLU][NDIM];
  logic [2:0]         asg_mem [NPTS];
  logic [3:0]         r_nk = 4'd2;
  logic [6:0]         r_np = 7'd64;
  logic [4:0]         r_nd = 5'd16;
  logic [7:0]         r_it = 8'd10;

  // stimulus-side record of which coordinates hold written data
  bit pt_ok [NPTS][NDIM];
  bit mn_ok [NCLU][NDIM];

  req_t pending [$];
  res_t cluster_q [$];
  int   errors = 0;
  int   n_items = 0;
  int   n_runs = 0;
  int   n_results = 0;
  int   stall_cnt = 0;
  int   gap = 0;
  bit   gaps_on = 1'b1;
  bit   taken = 1'b0;

  function automatic int sat(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned dist2(int p, int c, int nd);
    longint unsigned acc;
    longint diff;
    acc = 0;
    for (int d = 0; d < nd; d++) begin
      diff = longint'(pt_mem[p][d]) - longint'(mn_mem[c][d]);
      if (diff < 0) diff = -diff;
      acc += longint'(diff) * longint'(diff);
    end
    return acc;
  endfunction

  task automatic assign_points(int np, int nk, int nd);
    int best;
    longint unsigned bd, dd;
    for (int p = 0; p < np; p++) begin
      best = 0;
      bd = dist2(p, 0, nd);
      for (int c = 1; c < nk; c++) begin
        dd = dist2(p, c, nd);
        if (dd < bd) begin
          bd = dd;
          best = c;
        end
      end
      asg_mem[p] = best[2:0];
    end
  endtask

  task automatic cluster_run();
    int np, nk, nd, c;
    int sums [NCLU][NDIM];
    int cnt [NCLU];
    res_t r;
    nk = sat(r_nk, NCLU);
    np = sat(r_np, NPTS);
    nd = sat(r_nd, NDIM);
    for (int it = 0; it < r_it; it++) begin
      assign_points(np, nk, nd);
      for (int k = 0; k < NCLU; k++) begin
        cnt[k] = 0;
        for (int d = 0; d < NDIM; d++) sums[k][d] = 0;
      end
      for (int p = 0; p < np; p++) begin
        c = asg_mem[p];
        cnt[c]++;
        for (int d = 0; d < nd; d++) sums[c][d] += pt_mem[p][d];
      end
      for (int k = 0; k < nk; k++) begin
        if (cnt[k] != 0) begin
          for (int d = 0; d < nd; d++) mn_mem[k][d] = 16'(sums[k][d] / cnt[k]);
        end
      end
    end
    assign_points(np, nk, nd);
    for (int p = 0; p < np; p++) begin
      r.point_number   = p[5:0];
      r.cluster_number = asg_mem[p];
      r.last           = (p + 1 == np);
      cluster_q = {cluster_q, r};
    end
  endtask

  task automatic report(string what, res_t got, res_t want);
    errors++;
    $display("mismatch %s: got pt %0d cl %0d last %0d, want pt %0d cl %0d last %0d",
             what, got.point_number, got.cluster_number, got.last,
             want.point_number, want.cluster_number, want.last);
  endtask

  // accept transactions, predict, check results
  always @(posedge clk_i) begin
    bit moved;
    res_t want;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          REG_NUM_CLUSTERS: r_nk = cfg_data[3:0];
          REG_NUM_POINTS:   r_np = cfg_data[6:0];
          REG_NUM_DIMS:     r_nd = cfg_data[4:0];
          REG_ITERATIONS:   r_it = cfg_data;
          default: ;
        endcase
        moved = 1'b1;
      end
      if (start && !busy) begin
        taken = 1'b1;
        moved = 1'b1;
        n_items++;
        case (req.operation)
          OP_LOAD_POINT: pt_mem[req.entry_index][req.coord_index] = req.coord_value;
          OP_LOAD_MEAN:
            if (req.entry_index < NCLU) mn_mem[req.entry_index][req.coord_index] = req.coord_value;
          OP_RUN: begin
            n_runs++;
            cluster_run();
          end
          default: ;
        endcase
      end
      if (res_valid) begin
        moved = 1'b1;
        n_results++;
        if (cluster_q.size() == 0) begin
          report("unexpected", res, '0);
        end else begin
          want = cluster_q.pop_front();
          if (res.point_number !== want.point_number) report("point_number", res, want);
          if (res.cluster_number !== want.cluster_number) report("cluster_number", res, want);
          if (res.last !== want.last) report("last", res, want);
        end
      end
      stall_cnt = moved ? 0 : stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", cluster_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // drive transactions from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni && (!start || taken)) begin
      taken = 1'b0;
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4) - 1;
        start <= 1'b0;
      end else if (pending.size() > 0) begin
        start <= 1'b1;
        req   <= pending.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_item(logic [1:0] op, int ent, int crd, logic [15:0] val);
    req_t t;
    t.operation   = op;
    t.entry_index = ent[5:0];
    t.coord_index = crd[3:0];
    t.coord_value = val;
    pending = {pending, t};
    if (op == OP_LOAD_POINT) pt_ok[ent][crd] = 1'b1;
    if (op == OP_LOAD_MEAN && ent < NCLU) mn_ok[ent][crd] = 1'b1;
  endtask

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_run();
    int np, nk, nd;
    nk = sat(r_nk, NCLU);
    np = sat(r_np, NPTS);
    nd = sat(r_nd, NDIM);
    for (int p = 0; p < np; p++)
      for (int d = 0; d < nd; d++)
        if (!pt_ok[p][d]) push_item(OP_LOAD_POINT, p, d, rnd_coord());
    for (int c = 0; c < nk; c++)
      for (int d = 0; d < nd; d++)
        if (!mn_ok[c][d]) push_item(OP_LOAD_MEAN, c, d, rnd_coord());
    push_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 15), 16'($urandom));
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i); while (pending.size() != 0 || start || cluster_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_regs(int nk, int np, int nd, int it);
    write_reg(REG_NUM_CLUSTERS, nk[7:0]);
    write_reg(REG_NUM_POINTS, np[7:0]);
    write_reg(REG_NUM_DIMS, nd[7:0]);
    write_reg(REG_ITERATIONS, it[7:0]);
  endtask

  task automatic random_phase(int count, int run_pct);
    int np, nk, roll;
    np = sat(r_np, NPTS);
    nk = sat(r_nk, NCLU);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < run_pct) begin
        push_run();
      end else if (roll < run_pct + 5) begin
        push_item(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 15), 16'($urandom));
      end else if (roll < run_pct + 10) begin
        push_item(OP_LOAD_MEAN, $urandom_range(NCLU, 63), $urandom_range(0, 15), rnd_coord());
      end else if (roll < run_pct + 70) begin
        push_item(OP_LOAD_POINT, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                  : $urandom_range(0, np - 1), $urandom_range(0, 15), rnd_coord());
      end else begin
        push_item(OP_LOAD_MEAN, $urandom_range(0, nk - 1), $urandom_range(0, 15), rnd_coord());
      end
    end
    push_run();
    wait_quiet();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, ties, ignored items
    set_regs(2, 2, 2, 1);
    push_item(OP_LOAD_POINT, 0, 0, 16'h8000);
    push_item(OP_LOAD_POINT, 0, 1, 16'h7fff);
    push_item(OP_LOAD_POINT, 1, 0, 16'h7fff);
    push_item(OP_LOAD_POINT, 1, 1, 16'h8000);
    push_item(OP_LOAD_POINT, 63, 15, 16'hffff);
    push_item(OP_LOAD_MEAN, 0, 0, 16'h0000);
    push_item(OP_LOAD_MEAN, 0, 1, 16'h0000);
    push_item(OP_LOAD_MEAN, 1, 0, 16'h0000);
    push_item(OP_LOAD_MEAN, 1, 1, 16'h0000);
    push_item(OP_LOAD_MEAN, 63, 15, 16'h1234);
    push_item(OP_LOAD_MEAN, 7, 15, 16'h0100);
    push_item(OP_NONE, 63, 15, 16'hffff);
    push_run();
    push_item(OP_LOAD_MEAN, 1, 0, 16'h7fff);
    push_item(OP_LOAD_MEAN, 1, 1, 16'h8000);
    push_run();
    wait_quiet();
    write_reg(REG_ITERATIONS, 8'd0);
    push_run();
    wait_quiet();

    set_regs(3, 8, 3, 4);
    random_phase(50, 8);
    set_regs(1, 1, 1, 255);
    random_phase(20, 10);
    set_regs(8, 64, 1, 0);
    random_phase(30, 4);
    set_regs(0, 0, 0, 2);
    random_phase(30, 8);
    set_regs(15, 4, 2, 1);
    random_phase(20, 5);
    set_regs(2, 4, 31, 1);
    random_phase(20, 5);
    set_regs(3, 127, 1, 1);
    random_phase(20, 5);
    for (int ph = 0; ph < 4; ph++) begin
      set_regs($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(1, 4),
               $urandom_range(0, 20));
      if (ph == 3) gaps_on = 1'b0;
      random_phase(30, 8);
    end

    if (cluster_q.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", cluster_q.size());
    end
    $display("covered %0d transactions, %0d clustering runs, %0d results checked",
             n_items, n_runs, n_results);
    $display("register phases span minimum, maximum and saturating sizes and iteration counts");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
